// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Concurrent check, disabled while reset is asserted (active low).
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Concurrent check that also holds during reset.
`define ASSERT_CLK_NORST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_CLK_NORST(lbl, clk, prop, msg)
`endif
`endif

// ===== design/rslc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPM shift light controller package
// Word types, register codes, reset values and constants of the controller.
// ----------------------------------------------------------------------------
package rslc_pkg;

    // Sizes
    localparam int LED_MAX          = 6;
    localparam int LED_COUNT_DEF    = 6;
    localparam int BAR_W            = 20;
    localparam int BAR_SEGMENTS_DEF = 20;
    localparam int RPM_W            = 16;
    localparam int LOAD_W           = 16;
    localparam int LED_W            = 3;
    localparam int CFG_IDX_W        = 4;
    localparam int CFG_DATA_W       = 16;
    localparam int PCT_W            = 7;
    localparam int SEG_W            = 5;
    localparam int SEG_X_W          = 12;

    // Divider datapath
    localparam int LOAD_NUM_W  = 31;
    localparam int PCT_NUM_W   = 24;
    localparam int REM_W       = 17;
    localparam int NUM_W       = 16;
    localparam int QUO_W       = 16;
    localparam int CNT_W       = 4;
    localparam int LDIV_STEPS  = 16;
    localparam int PDIV_STEPS  = 7;

    typedef logic [LOAD_W-1:0] t_load;

    // Register codes
    localparam logic [CFG_IDX_W-1:0] CFG_RED_ZONE   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_ZONE = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_BASE   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_COUNT  = 4'd8;

    // Register reset values
    localparam t_load RED_ZONE_RESET   = 16'd24320;
    localparam t_load SHIFT_ZONE_RESET = 16'd23040;
    localparam t_load LED_THR_RESET [LED_MAX] = '{
        16'd12800, 16'd15360, 16'd17920, 16'd19200, 16'd20480, 16'd21760
    };

    // Arithmetic constants
    localparam logic [RPM_W-1:0]     DEFAULT_LIMIT = 16'd10000;
    localparam logic [14:0]          LOAD_SCALE    = 15'd25600;
    localparam t_load                LOAD_SAT      = 16'hFFFF;
    localparam logic [7:0]           PCT_SCALE     = 8'd200;
    localparam logic [PCT_W-1:0]     PCT_FULL      = 7'd100;
    localparam logic [SEG_X_W-1:0]   SEG_RND_LIN   = 12'd50;
    localparam logic [SEG_X_W-1:0]   SEG_RND_PRO   = 12'd100;
    localparam logic [12:0]          DIV100_RECIP  = 13'd5243;
    localparam int                   DIV100_SHIFT  = 19;

    // Input word
    typedef struct packed {
        logic [RPM_W-1:0] engine_rpm;
        logic [RPM_W-1:0] idle_rpm;
        logic [RPM_W-1:0] limit_rpm;
        logic             pro_style;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic [BAR_W-1:0] bar_mask;
        logic [LED_W-1:0] leds_lit;
        logic             in_red_zone;
        logic             red_blink_on;
        logic             bar_redraw;
        logic             leds_redraw;
    } t_out_word;

    // Register write word
    typedef struct packed {
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] wr_data;
    } t_cfg_word;

    // Divide a small value by 100 through a reciprocal (exact while the quotient fits SEG_W bits, below 3200)
    function automatic logic [SEG_W-1:0] seg_div100(input logic [SEG_X_W-1:0] x);
        logic [SEG_X_W+12:0] p;
        p = (SEG_X_W+13)'(x) * (SEG_X_W+13)'(DIV100_RECIP);
        return SEG_W'(p >> DIV100_SHIFT);
    endfunction

endpackage

// ===== design/rslc_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPM shift light controller stream interface
// Valid/ready channel carrying one payload word per handshake.
// ----------------------------------------------------------------------------
interface rslc_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/rpm_shift_light_controller_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPM shift light controller
// Works out engine load, red zone with hysteresis, progress LEDs and a
// 20-segment bar per frame, using one shared restoring divide step.
// ----------------------------------------------------------------------------
//  channel  dir  word        handshake
//  i_in     in   t_in_word   valid/ready, ready only while idle
//  o_out    out  t_out_word  valid/ready, registered output word
//  i_cfg    in   t_cfg_word  valid/ready, ready always high
//
//  A frame runs the load division (16 steps) and the percent division
//  (7 steps) before its result, and the next word is taken only once the
//  frame is done; saturating or degenerate frames skip steps. Both
//  divisions share one 17-bit subtract/compare unit. Reset is synchronous,
//  active low. The next word is accepted while a result waits; a frame holds
//  in its last state while the output register is still full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rpm_shift_light_controller_unit #(
    parameter int LED_COUNT    = rslc_pkg::LED_COUNT_DEF,
    parameter int BAR_SEGMENTS = rslc_pkg::BAR_SEGMENTS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rslc_stream_if.sink   i_in,
    rslc_stream_if.source o_out,
    rslc_stream_if.sink   i_cfg
);
    import rslc_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_PREP = 8'b0000_0010,
        ST_LCHK = 8'b0000_0100,
        ST_LDIV = 8'b0000_1000,
        ST_PSET = 8'b0001_0000,
        ST_PCHK = 8'b0010_0000,
        ST_PDIV = 8'b0100_0000,
        ST_FIN  = 8'b1000_0000
    } t_state;

    // Control and state registers
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_out_valid, n_out_valid;
    logic               r_red_latched, n_red_latched;
    logic [1:0]         r_blink_phase, n_blink_phase;
    logic [BAR_W-1:0]   r_prev_bar, n_prev_bar;
    logic [LED_W-1:0]   r_prev_leds, n_prev_leds;
    t_load              r_red_zone_load, n_red_zone_load;
    t_load              r_shift_zone_load, n_shift_zone_load;
    t_load              r_led_thr [LED_MAX];
    t_load              n_led_thr [LED_MAX];

    // Datapath registers
    t_in_word           r_in, n_in;
    logic [REM_W-1:0]   r_rem, n_rem;
    logic [NUM_W-1:0]   r_num, n_num;
    logic [REM_W-1:0]   r_div, n_div;
    logic [QUO_W-1:0]   r_quo, n_quo;
    t_load              r_load, n_load;
    logic [PCT_W-1:0]   r_pct, n_pct;
    t_out_word          r_out, n_out;

    // Shared divide unit
    logic               w_step;
    logic [REM_W:0]     w_opa;
    logic [REM_W+1:0]   w_diff;
    logic               w_ge;
    logic [REM_W-1:0]   w_rem;
    logic [QUO_W-1:0]   w_quo;

    // Frame setup
    logic               w_lim_zero;
    logic [RPM_W-1:0]   w_rpm, w_idle, w_lim, w_rpm_up, w_span, w_den;
    logic [LOAD_NUM_W-1:0] w_num;
    logic [PCT_NUM_W-1:0]  w_pnum;

    // Finish
    logic               w_out_free;
    logic               w_blink_on;
    logic               w_red;
    logic               w_zone_chg;
    logic [LED_W-1:0]   w_leds;
    logic               w_run;
    logic [SEG_X_W-1:0] w_seg_prod, w_seg_x;
    logic [SEG_W-1:0]   w_seg;
    logic [BAR_W-1:0]   w_full, w_grow, w_bar;
    logic               w_bar_rd, w_led_rd;

    assign i_in.ready   = (r_state == ST_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign o_out.valid  = r_out_valid;
    assign o_out.payload = r_out;

    // Restoring divide step: shift in one numerator bit, or compare only
    always_comb begin
        w_step = (r_state == ST_LDIV) || (r_state == ST_PDIV);
        w_opa  = w_step ? {r_rem, r_num[NUM_W-1]} : {1'b0, r_rem};
        w_diff = {1'b0, w_opa} - {2'b00, r_div};
        w_ge   = ~w_diff[REM_W+1];
        w_rem  = w_ge ? w_diff[REM_W-1:0] : w_opa[REM_W-1:0];
        w_quo  = {r_quo[QUO_W-2:0], w_ge};
    end

    // Clean up rpm values and form the load numerator
    always_comb begin
        w_lim_zero = (r_in.limit_rpm == '0);
        w_lim      = w_lim_zero ? DEFAULT_LIMIT : r_in.limit_rpm;
        w_idle     = w_lim_zero ? '0 : r_in.idle_rpm;
        w_rpm      = w_lim_zero ? '0 : r_in.engine_rpm;
        w_rpm_up   = (w_rpm < w_idle) ? w_idle : w_rpm;
        w_span     = w_rpm_up - w_idle;
        w_den      = w_lim - w_idle;
        w_num      = LOAD_NUM_W'(w_span) * LOAD_NUM_W'(LOAD_SCALE);
        w_pnum     = PCT_NUM_W'(r_load) * PCT_NUM_W'(PCT_SCALE)
                   + PCT_NUM_W'(r_shift_zone_load);
    end

    // Zone, LEDs and bar for the finished frame
    always_comb begin
        w_blink_on = ~r_blink_phase[1];
        w_red      = (r_load >= r_red_zone_load)
                   || (r_red_latched && (r_load >= r_shift_zone_load));
        w_zone_chg = (w_red != r_red_latched);

        // count leading thresholds at or below the load
        w_leds = '0;
        w_run  = 1'b1;
        for (int i = 0; i < LED_COUNT; i++) begin
            if (w_run && (r_load >= r_led_thr[i])) begin
                w_leds = LED_W'(i + 1);
            end else begin
                w_run = 1'b0;
            end
        end

        // segment count, rounded half up
        w_seg_prod = SEG_X_W'(r_pct) * SEG_X_W'(BAR_SEGMENTS);
        if (r_in.pro_style) begin
            w_seg_x = (w_seg_prod + SEG_RND_PRO) >> 1;
        end else begin
            w_seg_x = w_seg_prod + SEG_RND_LIN;
        end
        w_seg = seg_div100(w_seg_x);

        for (int i = 0; i < BAR_W; i++) begin
            w_full[i] = (i < BAR_SEGMENTS);
            w_grow[i] = (i < BAR_SEGMENTS)
                      && ((SEG_W'(i) < w_seg)
                          || (r_in.pro_style && (SEG_W'(BAR_SEGMENTS - 1 - i) < w_seg)));
        end

        if (w_red) begin
            w_bar    = w_blink_on ? w_full : '0;
            w_bar_rd = (w_bar != r_prev_bar) || w_zone_chg;
            w_led_rd = w_bar_rd;
        end else begin
            w_bar    = w_grow;
            w_bar_rd = (w_bar != r_prev_bar) || w_zone_chg;
            w_led_rd = (w_leds != r_prev_leds) || w_zone_chg;
        end
        w_out_free = ~r_out_valid || o_out.ready;
    end

    // Sequencer and next-state logic
    always_comb begin
        n_state           = r_state;
        n_cnt             = r_cnt;
        n_out_valid       = r_out_valid && !o_out.ready;
        n_red_latched     = r_red_latched;
        n_blink_phase     = r_blink_phase;
        n_prev_bar        = r_prev_bar;
        n_prev_leds       = r_prev_leds;
        n_red_zone_load   = r_red_zone_load;
        n_shift_zone_load = r_shift_zone_load;
        n_led_thr         = r_led_thr;
        n_in              = r_in;
        n_rem             = r_rem;
        n_num             = r_num;
        n_div             = r_div;
        n_quo             = r_quo;
        n_load            = r_load;
        n_pct             = r_pct;
        n_out             = r_out;

        // register writes
        if (i_cfg.valid) begin
            if (i_cfg.payload.reg_index == CFG_RED_ZONE) begin
                n_red_zone_load = i_cfg.payload.wr_data;
            end else if (i_cfg.payload.reg_index == CFG_SHIFT_ZONE) begin
                n_shift_zone_load = i_cfg.payload.wr_data;
            end else if ((i_cfg.payload.reg_index >= CFG_LED_BASE)
                         && (i_cfg.payload.reg_index < CFG_REG_COUNT)) begin
                n_led_thr[3'(i_cfg.payload.reg_index - CFG_LED_BASE)] =
                    i_cfg.payload.wr_data;
            end
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_in    = i_in.payload;
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                // degenerate spans skip the division
                if (w_lim == w_idle) begin
                    n_load  = LOAD_SAT;
                    n_state = ST_PSET;
                end else if (w_lim < w_idle) begin
                    n_load  = '0;
                    n_state = ST_PSET;
                end else begin
                    n_rem   = REM_W'(w_num[LOAD_NUM_W-1:NUM_W]);
                    n_num   = w_num[NUM_W-1:0];
                    n_div   = REM_W'(w_den);
                    n_state = ST_LCHK;
                end
            end
            ST_LCHK: begin
                // quotient of 2^16 or more saturates
                if (w_ge) begin
                    n_load  = LOAD_SAT;
                    n_state = ST_PSET;
                end else begin
                    n_quo   = '0;
                    n_cnt   = CNT_W'(LDIV_STEPS - 1);
                    n_state = ST_LDIV;
                end
            end
            ST_LDIV: begin
                n_rem = w_rem;
                n_num = {r_num[NUM_W-2:0], 1'b0};
                n_quo = w_quo;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_load  = w_quo;
                    n_state = ST_PSET;
                end
            end
            ST_PSET: begin
                if (r_shift_zone_load == '0) begin
                    n_pct   = PCT_FULL;
                    n_state = ST_FIN;
                end else begin
                    n_rem   = w_pnum[PCT_NUM_W-1:PCT_W];
                    n_num   = {w_pnum[PCT_W-1:0], (NUM_W-PCT_W)'(0)};
                    n_div   = {r_shift_zone_load, 1'b0};
                    n_state = ST_PCHK;
                end
            end
            ST_PCHK: begin
                // quotient of 128 or more clamps to full scale
                if (w_ge) begin
                    n_pct   = PCT_FULL;
                    n_state = ST_FIN;
                end else begin
                    n_quo   = '0;
                    n_cnt   = CNT_W'(PDIV_STEPS - 1);
                    n_state = ST_PDIV;
                end
            end
            ST_PDIV: begin
                n_rem = w_rem;
                n_num = {r_num[NUM_W-2:0], 1'b0};
                n_quo = w_quo;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_pct   = (w_quo[PCT_W-1:0] > PCT_FULL) ? PCT_FULL : w_quo[PCT_W-1:0];
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                // hold until the output register is free
                if (w_out_free) begin
                    n_blink_phase      = r_blink_phase + 1'b1;
                    n_red_latched      = w_red;
                    n_prev_bar         = w_bar;
                    n_out.bar_mask     = w_bar;
                    n_out.in_red_zone  = w_red;
                    n_out.bar_redraw   = w_bar_rd;
                    n_out.leds_redraw  = w_led_rd;
                    if (w_red) begin
                        n_out.leds_lit     = '0;
                        n_out.red_blink_on = w_blink_on;
                    end else begin
                        n_out.leds_lit     = w_leds;
                        n_out.red_blink_on = 1'b0;
                        n_prev_leds        = w_leds;
                    end
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= ST_IDLE;
            r_cnt             <= '0;
            r_out_valid       <= 1'b0;
            r_red_latched     <= 1'b0;
            r_blink_phase     <= '0;
            r_prev_bar        <= '0;
            r_prev_leds       <= '0;
            r_red_zone_load   <= RED_ZONE_RESET;
            r_shift_zone_load <= SHIFT_ZONE_RESET;
            r_led_thr         <= LED_THR_RESET;
        end else begin
            r_state           <= n_state;
            r_cnt             <= n_cnt;
            r_out_valid       <= n_out_valid;
            r_red_latched     <= n_red_latched;
            r_blink_phase     <= n_blink_phase;
            r_prev_bar        <= n_prev_bar;
            r_prev_leds       <= n_prev_leds;
            r_red_zone_load   <= n_red_zone_load;
            r_shift_zone_load <= n_shift_zone_load;
            r_led_thr         <= n_led_thr;
        end
    end

    // Datapath, no reset
    always_ff @(posedge i_clk) begin
        r_in   <= n_in;
        r_rem  <= n_rem;
        r_num  <= n_num;
        r_div  <= n_div;
        r_quo  <= n_quo;
        r_load <= n_load;
        r_pct  <= n_pct;
        r_out  <= n_out;
    end

    // Checks
    `ASSERT_CLK(a_accept_starts_setup, i_clk, i_rst_n, (i_in.valid && i_in.ready) |=> (r_state == ST_PREP), "accepted word did not start frame setup")
    `ASSERT_CLK(a_result_from_finish, i_clk, i_rst_n, $rose(r_out_valid) |-> ($past(r_state) == ST_FIN), "result word raised outside the finish step")
    `ASSERT_CLK(a_red_zone_word, i_clk, i_rst_n, (o_out.valid && o_out.payload.in_red_zone) |-> ((o_out.payload.leds_lit == '0) && (o_out.payload.bar_redraw == o_out.payload.leds_redraw)), "red zone word carries LED count or split redraw")
    `ASSERT_CLK(a_blink_needs_red, i_clk, i_rst_n, (o_out.valid && !o_out.payload.in_red_zone) |-> !o_out.payload.red_blink_on, "blink flag set outside the red zone")

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPM shift light controller testbench
// Drives frames and register writes into the controller, predicts every
// result word from its own copy of the registers and the zone, blink and
// redraw state, and compares each returned word field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import rslc_pkg::*;

    localparam int REG_COUNT     = int'(CFG_REG_COUNT);
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 3000;

    typedef enum int {
        NOISE_RAW, NOISE_NO_LIMIT, NOISE_FLAT, NOISE_INVERTED, NOISE_BELOW_IDLE,
        NOISE_EXTREME
    } t_noise_kind;

    typedef enum int {
        SET_RESET, SET_ORDERED, SET_RANDOM, SET_EXTREME
    } t_setting;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rslc_stream_if #(.t_payload(t_in_word))  in_if  ();
    rslc_stream_if #(.t_payload(t_out_word)) out_if ();
    rslc_stream_if #(.t_payload(t_cfg_word)) cfg_if ();

    rpm_shift_light_controller_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Predictor state: register file, zone latch, blink counter, last frame
    logic [CFG_DATA_W-1:0] cfg_regs [REG_COUNT];
    logic                  zone_latched;
    logic [1:0]            blink_count;
    logic [BAR_W-1:0]      last_bar;
    logic [LED_W-1:0]      last_leds;

    t_out_word frame_q [$];
    t_out_word due_word;
    int        errors;
    int        frames_sent;
    int        quiet_cycles;
    int        src_gap_pct;
    int        sink_stall_pct;

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic t_out_word predict_frame(input t_in_word w);
        logic [31:0]      rpm, idle, lim, load, pct, seg, shift;
        logic             blink, red, zone_flip, counting;
        logic [BAR_W-1:0] bar;
        logic [LED_W-1:0] leds;
        t_out_word        res;
        rpm   = w.engine_rpm;
        idle  = w.idle_rpm;
        lim   = w.limit_rpm;
        shift = cfg_regs[CFG_SHIFT_ZONE];
        bar   = '0;
        leds  = '0;
        res   = '0;

        // advance blink on every frame
        blink       = (blink_count < 2'd2);
        blink_count = blink_count + 2'd1;

        // engine load in 1/256 percent
        if (lim == 0) begin
            rpm  = 0;
            idle = 0;
            lim  = DEFAULT_LIMIT;
        end
        if (rpm < idle)
            rpm = idle;
        if (lim == idle) begin
            load = LOAD_SAT;
        end else if (lim < idle) begin
            load = 0;
        end else begin
            load = ((rpm - idle) * LOAD_SCALE) / (lim - idle);
            if (load > LOAD_SAT)
                load = LOAD_SAT;
        end

        // red zone with hysteresis
        red = (load >= cfg_regs[CFG_RED_ZONE]) || (zone_latched && load >= shift);
        zone_flip    = (red != zone_latched);
        zone_latched = red;

        if (red) begin
            bar              = blink ? {BAR_W{1'b1}} : '0;
            res.bar_redraw   = (bar != last_bar) || zone_flip;
            res.leds_redraw  = res.bar_redraw;
            res.red_blink_on = blink;
        end else begin
            // count leading thresholds at or below the load
            counting = 1'b1;
            for (int i = 0; i < LED_COUNT_DEF; i++) begin
                if (counting && load >= cfg_regs[int'(CFG_LED_BASE) + i])
                    leds = LED_W'(i + 1);
                else
                    counting = 1'b0;
            end
            if (shift == 0) begin
                pct = 100;
            end else begin
                pct = (load * 200 + shift) / (2 * shift);
                if (pct > 100)
                    pct = 100;
            end
            if (w.pro_style) begin
                seg = (pct * BAR_SEGMENTS_DEF + 100) / 200;
                for (int i = 0; i < BAR_SEGMENTS_DEF; i++) begin
                    if (i < seg) begin
                        bar[i]                        = 1'b1;
                        bar[BAR_SEGMENTS_DEF - 1 - i] = 1'b1;
                    end
                end
            end else begin
                seg = (pct * BAR_SEGMENTS_DEF + 50) / 100;
                for (int i = 0; i < BAR_SEGMENTS_DEF; i++) begin
                    if (i < seg)
                        bar[i] = 1'b1;
                end
            end
            res.bar_redraw   = (bar != last_bar) || zone_flip;
            res.leds_redraw  = (leds != last_leds) || zone_flip;
            res.red_blink_on = 1'b0;
            last_leds        = leds;
        end
        last_bar        = bar;
        res.bar_mask    = bar;
        res.leds_lit    = leds;
        res.in_red_zone = red;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int pick_gap(input int pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 50);
        return $urandom_range(1, 3);
    endfunction

    function automatic t_in_word make_frame(input logic [RPM_W-1:0] engine,
                                            input logic [RPM_W-1:0] idle,
                                            input logic [RPM_W-1:0] limit,
                                            input logic             pro);
        t_in_word w;
        w.engine_rpm = engine;
        w.idle_rpm   = idle;
        w.limit_rpm  = limit;
        w.pro_style  = pro;
        return w;
    endfunction

    // smallest engine speed giving at least the wanted load (limit above idle)
    function automatic logic [RPM_W-1:0] rpm_for_load(input int unsigned idle,
                                                      input int unsigned lim,
                                                      input int unsigned load);
        longint r;
        r = idle + (longint'(load) * (lim - idle) + 25599) / 25600;
        if (r > 65535)
            r = 65535;
        return RPM_W'(r);
    endfunction

    function automatic t_in_word noise_frame();
        t_in_word         w;
        t_noise_kind      kind;
        logic [RPM_W-1:0] tmp;
        w.engine_rpm = RPM_W'($urandom);
        w.idle_rpm   = RPM_W'($urandom);
        w.limit_rpm  = RPM_W'($urandom);
        w.pro_style  = 1'($urandom);
        kind = t_noise_kind'($urandom_range(0, 5));
        case (kind)
            NOISE_NO_LIMIT: w.limit_rpm = '0;
            NOISE_FLAT:     w.limit_rpm = w.idle_rpm;
            NOISE_INVERTED: begin
                if (w.limit_rpm > w.idle_rpm) begin
                    tmp         = w.limit_rpm;
                    w.limit_rpm = w.idle_rpm;
                    w.idle_rpm  = tmp;
                end
            end
            NOISE_BELOW_IDLE: begin
                if (w.idle_rpm == 0)
                    w.idle_rpm = 1;
                w.engine_rpm = RPM_W'($urandom_range(0, w.idle_rpm - 1));
            end
            NOISE_EXTREME: begin
                w.engine_rpm = $urandom_range(0, 1) ? '1 : '0;
                w.idle_rpm   = $urandom_range(0, 1) ? '1 : '0;
                w.limit_rpm  = $urandom_range(0, 1) ? '1 : '0;
            end
            default: ;
        endcase
        return w;
    endfunction

    // present one frame word, wait for it to be taken, predict its result
    task automatic send_frame(input t_in_word w);
        int gap;
        gap = pick_gap(src_gap_pct);
        repeat (gap) begin
            @(negedge i_clk);
            in_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_if.valid   <= 1'b1;
        in_if.payload <= w;
        do @(posedge i_clk); while (!in_if.ready);
        frame_q.push_back(predict_frame(w));
        frames_sent++;
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0]  idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_if.valid             <= 1'b1;
        cfg_if.payload.reg_index <= idx;
        cfg_if.payload.wr_data   <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        if (idx < CFG_REG_COUNT)
            cfg_regs[idx] = data;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // drop valid, drain all results, let the block settle
    task automatic wait_idle();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (frame_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_setting(input t_setting mode);
        logic [CFG_DATA_W-1:0] vals [REG_COUNT];
        int unsigned           shift, thr;
        case (mode)
            SET_RESET: begin
                vals[CFG_RED_ZONE]   = RED_ZONE_RESET;
                vals[CFG_SHIFT_ZONE] = SHIFT_ZONE_RESET;
                for (int i = 0; i < LED_MAX; i++)
                    vals[int'(CFG_LED_BASE) + i] = LED_THR_RESET[i];
            end
            SET_ORDERED: begin
                shift = $urandom_range(2000, 40000);
                vals[CFG_SHIFT_ZONE] = CFG_DATA_W'(shift);
                vals[CFG_RED_ZONE]   = CFG_DATA_W'(shift + $urandom_range(0, 4000));
                thr = $urandom_range(0, shift / 2);
                for (int i = 0; i < LED_MAX; i++) begin
                    vals[int'(CFG_LED_BASE) + i] = CFG_DATA_W'(thr);
                    thr += $urandom_range(0, shift / 8);
                end
            end
            SET_RANDOM: begin
                for (int i = 0; i < REG_COUNT; i++)
                    vals[i] = CFG_DATA_W'($urandom);
            end
            default: begin
                for (int i = 0; i < REG_COUNT; i++) begin
                    case ($urandom_range(0, 3))
                        0:       vals[i] = '0;
                        1:       vals[i] = 16'd1;
                        default: vals[i] = '1;
                    endcase
                end
            end
        endcase
        for (int i = 0; i < REG_COUNT; i++)
            write_register(CFG_IDX_W'(i), vals[i]);
        // an index past the register file must leave it untouched
        write_register(CFG_IDX_W'($urandom_range(REG_COUNT, 2**CFG_IDX_W - 1)),
                       CFG_DATA_W'($urandom));
    endtask

    task automatic pick_idling();
        case ($urandom_range(0, 3))
            0: begin src_gap_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_gap_pct = 30; sink_stall_pct = 0;  end
            2: begin src_gap_pct = 0;  sink_stall_pct = 40; end
            default: begin src_gap_pct = 25; sink_stall_pct = 25; end
        endcase
    endtask

    // ramp the load up past the red threshold and back down through the band
    task automatic run_sweep();
        int unsigned idle, lim, load, peak, step, n;
        logic        rising, pro;
        idle = $urandom_range(0, 3000);
        lim  = idle + $urandom_range(1500, 20000);
        pro  = 1'($urandom);
        step = $urandom_range(0, 1) ? $urandom_range(40, 600) : $urandom_range(600, 3000);
        peak = cfg_regs[CFG_RED_ZONE] + $urandom_range(0, 4000);
        if (peak > 65535)
            peak = 65535;
        load   = (peak > step * 12) ? peak - $urandom_range(0, step * 12) : 0;
        rising = 1'b1;
        n      = $urandom_range(10, 40);
        repeat (n) begin
            if ($urandom_range(0, 9) == 0)
                send_frame(noise_frame());
            else
                send_frame(make_frame(rpm_for_load(idle, lim, load), RPM_W'(idle),
                                      RPM_W'(lim), pro ^ ($urandom_range(0, 7) == 0)));
            if (rising) begin
                load += step;
                if (load >= peak)
                    rising = 1'b0;
            end else if (load > step) begin
                load -= step;
            end else begin
                load   = 0;
                rising = 1'b1;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed_frames();
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        // no limit data, then forced defaults
        send_frame(make_frame(16'd0, 16'd0, 16'd0, 1'b0));
        send_frame(make_frame(16'hFFFF, 16'hFFFF, 16'd0, 1'b1));
        // enter red, hold at the shift load, drop out just below
        send_frame(make_frame(16'hFFFF, 16'd0, 16'hFFFF, 1'b0));
        send_frame(make_frame(16'd9000, 16'd0, 16'd10000, 1'b1));
        send_frame(make_frame(16'd8999, 16'd0, 16'd10000, 1'b0));
        // re-enter exactly at the red load and stay there as the blink toggles
        send_frame(make_frame(16'd9500, 16'd0, 16'd10000, 1'b0));
        send_frame(make_frame(16'd9500, 16'd0, 16'd10000, 1'b1));
        send_frame(make_frame(16'd9500, 16'd0, 16'd10000, 1'b0));
        // first LED exactly at and just under its threshold, then all LEDs
        send_frame(make_frame(16'd5000, 16'd0, 16'd10000, 1'b0));
        send_frame(make_frame(16'd4999, 16'd0, 16'd10000, 1'b0));
        send_frame(make_frame(16'd8500, 16'd0, 16'd10000, 1'b1));
        send_frame(make_frame(16'd8500, 16'd0, 16'd10000, 1'b1));
        // zero divisor, limit below idle, rpm below idle, huge quotient
        send_frame(make_frame(16'd3000, 16'd3000, 16'd3000, 1'b0));
        send_frame(make_frame(16'd5000, 16'd6000, 16'd4000, 1'b1));
        send_frame(make_frame(16'd100, 16'd800, 16'd7000, 1'b0));
        send_frame(make_frame(16'hFFFF, 16'd0, 16'd1, 1'b0));
        send_frame(make_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
        wait_idle();
    endtask

    task automatic test_register_writes();
        src_gap_pct    = 20;
        sink_stall_pct = 20;
        // all registers cleared
        for (int i = 0; i < REG_COUNT; i++)
            write_register(CFG_IDX_W'(i), '0);
        repeat (3) send_frame(noise_frame());
        wait_idle();
        // all registers at full scale
        for (int i = 0; i < REG_COUNT; i++)
            write_register(CFG_IDX_W'(i), '1);
        repeat (3) send_frame(noise_frame());
        wait_idle();
        // every unused index, then back to reset values
        for (int i = REG_COUNT; i < 2**CFG_IDX_W; i++)
            write_register(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
        apply_setting(SET_RESET);
        repeat (3) send_frame(noise_frame());
        wait_idle();
    endtask

    task automatic test_red_zone_sweeps();
        int target;
        for (int phase = 0; phase < 9; phase++) begin
            apply_setting((phase < 4) ? t_setting'(phase) : t_setting'($urandom_range(0, 3)));
            pick_idling();
            target = frames_sent + 100;
            while (frames_sent < target)
                run_sweep();
            wait_idle();
        end
    endtask

    task automatic test_random_frames();
        int unsigned idle, lim, load;
        for (int phase = 0; phase < 3; phase++) begin
            apply_setting(t_setting'($urandom_range(1, 3)));
            pick_idling();
            repeat (110) begin
                if ($urandom_range(0, 9) < 6) begin
                    send_frame(noise_frame());
                end else begin
                    // land near one of the register loads
                    idle = $urandom_range(0, 4000);
                    lim  = idle + $urandom_range(1, 30000);
                    load = cfg_regs[$urandom_range(0, REG_COUNT - 1)] + $urandom_range(0, 4);
                    load = (load > 2) ? load - 2 : 0;
                    send_frame(make_frame(rpm_for_load(idle, lim, load), RPM_W'(idle),
                                          RPM_W'(lim), 1'($urandom)));
                end
            end
            wait_idle();
        end
    endtask

    // ------------------------------------------------------------------------
    // Result sink: random stalls, with stretches of none
    // ------------------------------------------------------------------------
    initial begin
        int stall_left;
        int n;
        stall_left   = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left != 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else begin
                n = pick_gap(sink_stall_pct);
                if (n == 0) begin
                    out_if.ready <= 1'b1;
                end else begin
                    out_if.ready <= 1'b0;
                    stall_left = n - 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result check: compare each accepted word with the oldest prediction
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (frame_q.size() == 0) begin
                $display("%0t: result word with none expected, actual %0h",
                         $time, out_if.payload);
                errors++;
            end else begin
                due_word = frame_q.pop_front();
                check_field("bar_mask", due_word.bar_mask, out_if.payload.bar_mask);
                check_field("leds_lit", due_word.leds_lit, out_if.payload.leds_lit);
                check_field("in_red_zone", due_word.in_red_zone, out_if.payload.in_red_zone);
                check_field("red_blink_on", due_word.red_blink_on,
                            out_if.payload.red_blink_on);
                check_field("bar_redraw", due_word.bar_redraw, out_if.payload.bar_redraw);
                check_field("leds_redraw", due_word.leds_redraw, out_if.payload.leds_redraw);
            end
        end
    end

    // Watchdog: end the run when no word moves for too long
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
            || (cfg_if.valid && cfg_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n        = 1'b0;
        in_if.valid    = 1'b0;
        in_if.payload  = '0;
        cfg_if.valid   = 1'b0;
        cfg_if.payload = '0;
        errors         = 0;
        frames_sent    = 0;
        quiet_cycles   = 0;
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        cfg_regs[CFG_RED_ZONE]   = RED_ZONE_RESET;
        cfg_regs[CFG_SHIFT_ZONE] = SHIFT_ZONE_RESET;
        for (int i = 0; i < LED_MAX; i++)
            cfg_regs[int'(CFG_LED_BASE) + i] = LED_THR_RESET[i];
        zone_latched = 1'b0;
        blink_count  = '0;
        last_bar     = '0;
        last_leds    = '0;

        // hold reset, release on a falling edge
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_frames();
        test_register_writes();
        test_red_zone_sweeps();
        test_random_frames();
        wait_idle();

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/rslc_pkg.sv
design/rslc_stream_if.sv
design/rpm_shift_light_controller_unit.sv
tb/sv/tb_top.sv
